// File: rtl/knx_rtr_pkg.sv
package knx_rtr_pkg;

  localparam int MAX_DATA_LENGTH_DEF = 16;

  localparam int HDR_BYTES  = 8;
  localparam int SVC_LEN    = 8;
  localparam int FIXED_PART = 16;

  localparam logic [7:0]  HDR_LEN         = 8'h06;
  localparam logic [7:0]  PROTO_VER       = 8'h10;
  localparam logic [15:0] SVC_ROUTING_IND = 16'h0530;
  localparam logic [7:0]  MSG_LDATA_IND   = 8'h29;
  localparam logic [7:0]  FIRST_MASK      = 8'h3f;
  localparam logic [3:0]  CMD_MAX         = 4'd2;
  localparam int          GROUP_BIT       = 7;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_TRUNC    = 3'd1,
    STS_HEADER   = 3'd2,
    STS_SERVICE  = 3'd3,
    STS_LENGTH   = 3'd4,
    STS_MESSAGE  = 3'd5,
    STS_NOTGROUP = 3'd6,
    STS_COMMAND  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] source_addr;
    logic [15:0] dest_addr;
    logic [1:0]  cmd;
    logic [4:0]  payload_len;
    logic [7:0]  payload_byte;
    logic        final_result;
  } out_word_t;

endpackage

// File: rtl/knxnet_ip_routing_frame_parser_top.sv
// Routing-indication packet parser with a cEMI L_Data.ind payload.
// Input channel: one packet byte per word (in_data.rx_byte), in order from
// byte zero, with in_data.rx_last set on the final byte. A word is taken at
// a clock edge where in_valid is high and in_stall is low.
// Output channel: one word per data byte on success, or a single word that
// carries the error status. The last word of a packet has final_result set.
// Timing: packet bytes are taken one per cycle while in_stall is low. After
// the final byte the block passes through the check state, which registers
// the header check status, then the drain state, which loads one result per
// cycle into the output register while the receiver does not stall. in_stall
// stays high through both states. The drain rate is set by the single read
// port of the data buffer memory, read one entry ahead.
// Bytes of the next packet are accepted while the last result still waits
// in the output register. When the receiver stalls, the output word holds
// and the drain pauses.
// Reset clears the byte count, the overflow flag, the state, the drain index
// and out_valid. The header, service and data stores are not cleared; entries
// a packet did not write are never needed by a packet that passes the checks.
module knxnet_ip_routing_frame_parser_top
  import knx_rtr_pkg::*;
#(
  parameter int MAX_DATA_LENGTH = MAX_DATA_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int DIDX_W = (MAX_DATA_LENGTH > 1) ? $clog2(MAX_DATA_LENGTH) : 1;
  localparam int EIDX_W = $clog2(MAX_DATA_LENGTH + 1);
  localparam logic [15:0]       MAX_LEN16 = 16'(MAX_DATA_LENGTH);
  localparam logic [7:0]        MAX_LEN8  = 8'(MAX_DATA_LENGTH);
  localparam logic [EIDX_W-1:0] MAX_LENI  = EIDX_W'(MAX_DATA_LENGTH);

  state_t state_r, state_nxt;

  logic [15:0]       cnt_r;
  logic              ovf_r;
  logic [7:0]        hdr_r [HDR_BYTES];
  logic [7:0]        svc_r [SVC_LEN];
  logic [1:0]        d0_hi_r;
  logic [7:0]        data_mem [MAX_DATA_LENGTH];
  logic [7:0]        rd_data_r;
  logic [EIDX_W-1:0] emit_idx_r, emit_idx_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              in_accept;
  logic [8:0]        svc_off;
  logic [15:0]       rel;
  logic [15:0]       data_off;
  logic              in_hdr;
  logic              pos_ge_off;
  logic              hdr_we;
  logic              svc_we;
  logic              data_we;
  logic [DIDX_W-1:0] rd_addr;

  logic [16:0]       svc_end;
  logic [16:0]       room;
  logic [7:0]        dlen;
  logic [3:0]        cmd_code;

  logic              load;
  logic              emit_last;
  logic              emit_final;
  out_word_t         result;

  assign in_accept = in_valid && !in_stall;

  // Byte placement: header first, service info after the additional info,
  // then the data bytes.
  always_comb begin
    svc_off    = 9'(hdr_r[7]) + 9'(HDR_BYTES);
    in_hdr     = cnt_r < 16'(HDR_BYTES);
    pos_ge_off = cnt_r >= 16'(svc_off);
    rel        = cnt_r - 16'(svc_off);
    data_off   = rel - 16'(SVC_LEN);
    hdr_we     = in_accept && !ovf_r && in_hdr;
    svc_we     = in_accept && !ovf_r && !in_hdr && pos_ge_off && (rel < 16'(SVC_LEN));
    data_we    = in_accept && !ovf_r && !in_hdr && pos_ge_off &&
                 (rel >= 16'(SVC_LEN)) && (data_off < MAX_LEN16);
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[cnt_r[2:0]] <= in_data.rx_byte;
    end
    if (svc_we) begin
      svc_r[rel[2:0]] <= in_data.rx_byte;
    end
    if (data_we && (data_off[DIDX_W-1:0] == '0)) begin
      d0_hi_r <= in_data.rx_byte[7:6];
    end
  end

  // Packet checks, evaluated in the cycle after the final byte.
  always_comb begin
    svc_end  = 17'(svc_off) + 17'(SVC_LEN);
    room     = 17'(cnt_r) - svc_end;
    dlen     = svc_r[6];
    cmd_code = {svc_r[7][1:0], d0_hi_r};
    priority if (!ovf_r && (cnt_r < 16'(FIXED_PART))) begin
      status_nxt = STS_TRUNC;
    end else if ((hdr_r[0] != HDR_LEN) || (hdr_r[1] != PROTO_VER)) begin
      status_nxt = STS_HEADER;
    end else if ({hdr_r[2], hdr_r[3]} != SVC_ROUTING_IND) begin
      status_nxt = STS_SERVICE;
    end else if (ovf_r || ({hdr_r[4], hdr_r[5]} != cnt_r)) begin
      status_nxt = STS_LENGTH;
    end else if (hdr_r[6] != MSG_LDATA_IND) begin
      status_nxt = STS_MESSAGE;
    end else if (17'(cnt_r) < svc_end) begin
      status_nxt = STS_TRUNC;
    end else if (!svc_r[1][GROUP_BIT]) begin
      status_nxt = STS_NOTGROUP;
    end else if ((dlen == 8'd0) || (dlen > MAX_LEN8) || (17'(dlen) != room)) begin
      status_nxt = STS_LENGTH;
    end else if (cmd_code > CMD_MAX) begin
      status_nxt = STS_COMMAND;
    end else begin
      status_nxt = STS_OK;
    end
  end

  // Result assembly during the drain.
  always_comb begin
    load       = !out_valid_r || !out_stall;
    emit_last  = (8'(emit_idx_r) + 8'd1) == dlen;
    emit_final = (status_r != STS_OK) || emit_last;
    result     = '0;
    result.status       = status_r;
    result.final_result = 1'b1;
    if (status_r == STS_OK) begin
      result.source_addr  = {svc_r[2], svc_r[3]};
      result.dest_addr    = {svc_r[4], svc_r[5]};
      result.cmd          = cmd_code[1:0];
      result.payload_len  = dlen[4:0];
      result.payload_byte = (emit_idx_r == '0) ? (rd_data_r & FIRST_MASK) : rd_data_r;
      result.final_result = emit_last;
    end
  end

  always_comb begin
    emit_idx_nxt = emit_idx_r;
    if (state_r == ST_CHECK) begin
      emit_idx_nxt = '0;
    end else if ((state_r == ST_EMIT) && load && !emit_final) begin
      emit_idx_nxt = emit_idx_r + EIDX_W'(1);
    end
    rd_addr = (emit_idx_nxt < MAX_LENI) ? emit_idx_nxt[DIDX_W-1:0] : '0;
  end

  // Data buffer. The read address runs one step ahead of emit_idx_r, so
  // rd_data_r always holds the entry being emitted.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_off[DIDX_W-1:0]] <= in_data.rx_byte;
    end
    rd_data_r <= data_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RECV: begin
        if (in_accept && in_data.rx_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && emit_final) begin
          state_nxt = ST_RECV;
        end
      end
      default: begin
        state_nxt = ST_RECV;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_RECV:  in_stall = 1'b0;
      ST_CHECK: in_stall = 1'b1;
      ST_EMIT:  in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RECV;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emit_idx_r <= emit_idx_nxt;
      if (state_r == ST_CHECK) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (in_accept) begin
        if (cnt_r == 16'hffff) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 16'd1;
        end
      end
      if ((state_r == ST_EMIT) && load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      status_r <= status_nxt;
    end
    if ((state_r == ST_EMIT) && load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_check_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |=> (state_r == ST_EMIT))
    else $error("check state did not hand over to the drain");

  a_emit_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_idx_r < MAX_LENI))
    else $error("drain index ran past the data buffer");

  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STS_OK)) |-> out_data.final_result)
    else $error("error word not marked as the final result");

endmodule
